// ===== src/hpq_pkg.sv =====
`default_nettype none
package hpq_pkg;

    // Number of cells in the chain, one element per cell
    localparam int CAPACITY = 127;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OUT_CNT_W = 7;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic signed [VAL_W-1:0] top_value;
        logic [OUT_CNT_W-1:0]    count;
    } t_rsp;

    // What one cell hands to its right-hand neighbor
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    hold;
    } t_link;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                    en;
        logic                    del;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/hpq_cell.sv =====
`default_nettype none
module hpq_cell
    import hpq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_cmd                    i_cmd,
    input  wire logic                    i_occupied,
    input  wire t_link                   i_left,
    input  wire logic signed [VAL_W-1:0] i_right_value,
    output t_link                        o_link
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    // Keep this element in place when it is at least the inserted value
    assign o_link.value = r_value;
    assign o_link.hold  = i_occupied && !(r_value < i_cmd.value);

    // Select the next element: shift left on delete, open a slot on insert
    always_comb begin
        n_value = r_value;
        if (i_cmd.del) begin
            n_value = i_right_value;
        end else if (!o_link.hold) begin
            n_value = i_left.hold ? i_cmd.value : i_left.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_value <= n_value;
        end
    end

endmodule
`default_nettype wire

// ===== src/max_heap_priority_queue.sv =====
`default_nettype none
// Priority queue of signed 32-bit values, largest first.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries a request: insert
// a value or delete the maximum. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns one response per request: status, removed value, the
// maximum after the operation and the element count.
// Elements sit in a chain of cells kept in descending order. Every request is
// done in the cycle it is accepted: each cell compares its element with the
// broadcast value and takes its own, its left neighbor's or its right
// neighbor's element. The response is registered and appears in the cycle after
// the request is accepted; one request is accepted per cycle while the output
// register is free or being drained.
// When the receiver stalls, the response holds and no new request is taken.
// Reset empties the queue and clears the output valid flag; the cell contents
// are not cleared, since only occupied cells are ever read.
// An insert into a full queue or a delete from an empty one reports an error
// status and changes nothing.
module max_heap_priority_queue
    import hpq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_rsp             r_out;
    t_rsp             n_out;
    logic             w_accept;
    logic             w_ok;
    t_cmd             w_cmd;
    t_link            w_link [CAPACITY];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Check request against the fill level
    always_comb begin
        if (i_in_data.req_type == REQ_DELETE) begin
            w_ok = (r_count != '0);
        end else begin
            w_ok = (r_count < CNT_W'(CAPACITY));
        end
    end

    assign w_cmd.en    = w_accept && w_ok;
    assign w_cmd.del   = (i_in_data.req_type == REQ_DELETE);
    assign w_cmd.value = i_in_data.value;

    // Build the chain of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_link                   w_left;
        logic signed [VAL_W-1:0] w_right;

        if (gi == 0) begin : g_head
            assign w_left.value = '0;
            assign w_left.hold  = 1'b1;
        end else begin : g_body
            assign w_left = w_link[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = w_link[gi].value;
        end else begin : g_mid
            assign w_right = w_link[gi+1].value;
        end

        hpq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_occupied    (CNT_W'(gi) < r_count),
            .i_left        (w_left),
            .i_right_value (w_right),
            .o_link        (w_link[gi])
        );
    end

    // Form the response from the current front of the chain
    always_comb begin
        n_count             = r_count;
        n_out.status        = ST_OK;
        n_out.removed_value = '0;
        n_out.top_value     = (r_count == '0) ? '0 : w_link[0].value;
        if (!w_ok) begin
            n_out.status = w_cmd.del ? ST_EMPTY : ST_FULL;
        end else if (w_cmd.del) begin
            n_count             = r_count - CNT_W'(1);
            n_out.removed_value = w_link[0].value;
            n_out.top_value     = (r_count == CNT_W'(1)) ? '0 : w_link[1].value;
        end else begin
            n_count = r_count + CNT_W'(1);
            if (r_count == '0 || w_link[0].value < w_cmd.value) begin
                n_out.top_value = w_cmd.value;
            end
        end
        n_out.count = n_count[OUT_CNT_W-1:0];
    end

    // Advance fill level and hold the response until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
